// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check an expression at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check a consequent in the same cycle as its antecedent
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequent in the cycle after its antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- rtl/core/rtc_pkg.sv -----
// ----------------------------------------------------------------------------
// RTC package
// Types, operation codes and calendar helper functions for the clock block.
// ----------------------------------------------------------------------------
package rtc_pkg;

   // Operation codes
   localparam logic [1:0] OP_TICK     = 2'd0;
   localparam logic [1:0] OP_SET_TIME = 2'd1;
   localparam logic [1:0] OP_SET_DATE = 2'd2;
   localparam logic [1:0] OP_READ     = 2'd3;

   // Range limits
   localparam logic [7:0] HOUR_MAX   = 8'd23;
   localparam logic [7:0] MINSEC_MAX = 8'd59;
   localparam logic [7:0] DAY_MAX    = 8'd31;
   localparam logic [7:0] MONTH_MAX  = 8'd12;
   localparam logic [7:0] YEAR_MAX   = 8'd99;

   // Reciprocal of ten for values below 100: tens = (v * 205) >> 11
   localparam logic [14:0] TENS_RECIP = 15'd205;
   localparam int unsigned TENS_SHIFT = 11;

   // Weekday bias after folding the fixed century terms, mod 7
   localparam logic [7:0] WDAY_BIAS_JANFEB = 8'd3;
   localparam logic [7:0] WDAY_BIAS_LATER  = 8'd2;

   typedef struct packed {
      logic [1:0] op;
      logic       bcd;
      logic [7:0] set_hour;
      logic [7:0] set_minute;
      logic [7:0] set_second;
      logic [7:0] set_day;
      logic [7:0] set_month;
      logic [7:0] set_year;
   } req_type;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [4:0] day;
      logic [3:0] month;
      logic [6:0] year;
      logic [2:0] weekday;
   } cal_type;

   // BCD byte to binary: high nibble * 10 + low nibble
   function automatic logic [7:0] from_bcd(input logic [7:0] v);
      return 8'({v[7:4], 3'b000}) + 8'({v[7:4], 1'b0}) + 8'(v[3:0]);
   endfunction

   // Binary value below 100 to BCD byte
   function automatic logic [7:0] to_bcd(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  tens_x10;
      logic [6:0]  ones;
      prod     = 15'(v) * TENS_RECIP;
      tens     = 4'(prod >> TENS_SHIFT);
      tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
      ones     = v - tens_x10;
      return {tens, ones[3:0]};
   endfunction

   // Days in a month, leap every fourth year
   function automatic logic [4:0] month_length(input logic [3:0] m, input logic [6:0] y);
      logic [4:0] len;
      unique case (m)
         4'd2:                      len = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

   // Month term of the weekday sum: (23 * m) / 9
   function automatic logic [4:0] month_offset(input logic [3:0] m);
      logic [4:0] off;
      unique case (m)
         4'd1:    off = 5'd2;
         4'd2:    off = 5'd5;
         4'd3:    off = 5'd7;
         4'd4:    off = 5'd10;
         4'd5:    off = 5'd12;
         4'd6:    off = 5'd15;
         4'd7:    off = 5'd17;
         4'd8:    off = 5'd20;
         4'd9:    off = 5'd23;
         4'd10:   off = 5'd25;
         4'd11:   off = 5'd28;
         4'd12:   off = 5'd30;
         default: off = 5'd0;
      endcase
      return off;
   endfunction

   // Byte mod 7 by folding octal digits (8 is 1 mod 7)
   function automatic logic [2:0] mod7(input logic [7:0] x);
      logic [4:0] s1;
      logic [3:0] s2;
      s1 = 5'(x[7:6]) + 5'(x[5:3]) + 5'(x[2:0]);
      s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
      return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
   endfunction

   // Day of week for a date in 2000..2099, 0 is Sunday
   function automatic logic [2:0] calc_weekday(input logic [4:0] d, input logic [3:0] m,
                                               input logic [6:0] y);
      logic [7:0] leaps;
      logic [7:0] bias;
      logic [7:0] sum;
      if (m < 4'd3) begin
         leaps = (8'(y) + 8'd3) >> 2;
         bias  = WDAY_BIAS_JANFEB;
      end else begin
         leaps = 8'(y) >> 2;
         bias  = WDAY_BIAS_LATER;
      end
      sum = 8'(month_offset(m)) + 8'(d) + 8'(y) + leaps + bias;
      return mod7(sum);
   endfunction

endpackage

// ----- rtl/core/rtc_time_and_calendar.sv -----
// ----------------------------------------------------------------------------
// Real-time clock and calendar
// One-second tick, checked set time / set date and read, with decimal or
// BCD formatting of the result. Years 2000 to 2099.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Contents
//   req_*     in         req_valid / req_ready  op, bcd, set time and date
//   rsp_*     out        rsp_valid / rsp_ready  status, time, date, weekday
//
// A transaction is captured in the input register, processed when the output
// register can take it and its result lands there: one transaction per cycle
// sustained while responses are not stalled. The calendar update is a single
// combinational pass between those registers. A stalled response holds the
// output register; the input register keeps taking work until both are full.
// Reset brings the clock to 00:00:00, 1 Jan 2000, weekday 0.
//
module rtc_time_and_calendar (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_op,
   input  logic       req_bcd,
   input  logic [7:0] req_set_hour,
   input  logic [7:0] req_set_minute,
   input  logic [7:0] req_set_second,
   input  logic [7:0] req_set_day,
   input  logic [7:0] req_set_month,
   input  logic [7:0] req_set_year,

   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_status,
   output logic [5:0] rsp_out_hour,
   output logic [6:0] rsp_out_minute,
   output logic [6:0] rsp_out_second,
   output logic [5:0] rsp_out_day,
   output logic [4:0] rsp_out_month,
   output logic [7:0] rsp_out_year,
   output logic [2:0] rsp_out_weekday
);

`include "assert_macros.svh"

   logic             req_valid_ff;
   rtc_pkg::req_type req_data_ff;
   rtc_pkg::req_type req_data_in;
   logic             fire;

   rtc_pkg::cal_type cal_cur;
   rtc_pkg::cal_type cal_upd;
   logic             core_status;

   logic             rsp_valid_ff;
   logic             rsp_status_ff;
   logic [5:0]       rsp_hour_ff,    rsp_hour_in;
   logic [6:0]       rsp_minute_ff,  rsp_minute_in;
   logic [6:0]       rsp_second_ff,  rsp_second_in;
   logic [5:0]       rsp_day_ff,     rsp_day_in;
   logic [4:0]       rsp_month_ff,   rsp_month_in;
   logic [7:0]       rsp_year_ff,    rsp_year_in;
   logic [2:0]       rsp_weekday_ff;

   // Process when the input register holds work and the output can take it
   assign fire      = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || fire;

   always_comb begin
      req_data_in.op         = req_op;
      req_data_in.bcd        = req_bcd;
      req_data_in.set_hour   = req_set_hour;
      req_data_in.set_minute = req_set_minute;
      req_data_in.set_second = req_set_second;
      req_data_in.set_day    = req_set_day;
      req_data_in.set_month  = req_set_month;
      req_data_in.set_year   = req_set_year;
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_data_ff <= req_data_in;
      end
   end

   rtc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .req     (req_data_ff),
      .cal_cur (cal_cur),
      .cal_upd (cal_upd),
      .status  (core_status)
   );

   // Format the updated calendar for the response
   always_comb begin
      if (req_data_ff.bcd) begin
         rsp_hour_in   = 6'(rtc_pkg::to_bcd(7'(cal_upd.hour)));
         rsp_minute_in = 7'(rtc_pkg::to_bcd(7'(cal_upd.minute)));
         rsp_second_in = 7'(rtc_pkg::to_bcd(7'(cal_upd.second)));
         rsp_day_in    = 6'(rtc_pkg::to_bcd(7'(cal_upd.day)));
         rsp_month_in  = 5'(rtc_pkg::to_bcd(7'(cal_upd.month)));
         rsp_year_in   = rtc_pkg::to_bcd(cal_upd.year);
      end else begin
         rsp_hour_in   = 6'(cal_upd.hour);
         rsp_minute_in = 7'(cal_upd.minute);
         rsp_second_in = 7'(cal_upd.second);
         rsp_day_in    = 6'(cal_upd.day);
         rsp_month_in  = 5'(cal_upd.month);
         rsp_year_in   = 8'(cal_upd.year);
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_status_ff  <= core_status;
         rsp_hour_ff    <= rsp_hour_in;
         rsp_minute_ff  <= rsp_minute_in;
         rsp_second_ff  <= rsp_second_in;
         rsp_day_ff     <= rsp_day_in;
         rsp_month_ff   <= rsp_month_in;
         rsp_year_ff    <= rsp_year_in;
         rsp_weekday_ff <= cal_upd.weekday;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_hour    = rsp_hour_ff;
   assign rsp_out_minute  = rsp_minute_ff;
   assign rsp_out_second  = rsp_second_ff;
   assign rsp_out_day     = rsp_day_ff;
   assign rsp_out_month   = rsp_month_ff;
   assign rsp_out_year    = rsp_year_ff;
   assign rsp_out_weekday = rsp_weekday_ff;

   // Only a set operation can be rejected
   `ASSERT_IMPLY(a_status_on_set, clock, reset, fire && core_status, (req_data_ff.op == rtc_pkg::OP_SET_TIME) || (req_data_ff.op == rtc_pkg::OP_SET_DATE), "status raised for a tick or read")

   // A rejected set leaves the calendar untouched
   `ASSERT_NEXT(a_reject_holds, clock, reset, fire && core_status, $stable(cal_cur), "rejected set changed the calendar")

   // The calendar stays in range
   `ASSERT_ALWAYS(a_cal_range, clock, reset, (cal_cur.hour <= 5'd23) && (cal_cur.minute <= 6'd59) && (cal_cur.second <= 6'd59) && (cal_cur.day != 5'd0) && (cal_cur.month != 4'd0) && (cal_cur.month <= 4'd12) && (cal_cur.year <= 7'd99) && (cal_cur.weekday <= 3'd6), "calendar register out of range")

   // Input stalls only when both registers are full and the output is blocked
   `ASSERT_IMPLY(a_stall_cause, clock, reset, !req_ready, req_valid_ff && rsp_valid_ff && !rsp_ready, "input stalled without a full pipeline")

endmodule

// ----- rtl/core/rtc_core.sv -----
// ----------------------------------------------------------------------------
// RTC calendar core
// Holds the time and date registers and works out their update for one
// transaction: tick cascade, checked set time, checked set date, or read.
// ----------------------------------------------------------------------------
module rtc_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  rtc_pkg::req_type req,
   output rtc_pkg::cal_type cal_cur,
   output rtc_pkg::cal_type cal_upd,
   output logic             status
);

   rtc_pkg::cal_type cal_ff;
   rtc_pkg::cal_type cal_in;

   logic [7:0] set_h;
   logic [7:0] set_mi;
   logic [7:0] set_s;
   logic [7:0] set_d;
   logic [7:0] set_mo;
   logic [7:0] set_y;
   logic       time_bad;
   logic       date_bad;

   logic [4:0] roll_day;
   logic [3:0] roll_month;
   logic [6:0] roll_year;
   logic [4:0] wd_day;
   logic [3:0] wd_month;
   logic [6:0] wd_year;
   logic [2:0] wd_new;

   // Convert set values and range-check them
   always_comb begin
      set_h  = req.bcd ? rtc_pkg::from_bcd(req.set_hour)   : req.set_hour;
      set_mi = req.bcd ? rtc_pkg::from_bcd(req.set_minute) : req.set_minute;
      set_s  = req.bcd ? rtc_pkg::from_bcd(req.set_second) : req.set_second;
      set_d  = req.bcd ? rtc_pkg::from_bcd(req.set_day)    : req.set_day;
      set_mo = req.bcd ? rtc_pkg::from_bcd(req.set_month)  : req.set_month;
      set_y  = req.bcd ? rtc_pkg::from_bcd(req.set_year)   : req.set_year;
      time_bad = (set_h > rtc_pkg::HOUR_MAX) || (set_mi > rtc_pkg::MINSEC_MAX) ||
                 (set_s > rtc_pkg::MINSEC_MAX);
      date_bad = (set_d == 8'd0) || (set_d > rtc_pkg::DAY_MAX) || (set_mo == 8'd0) ||
                 (set_mo > rtc_pkg::MONTH_MAX) || (set_y > rtc_pkg::YEAR_MAX);
   end

   // Roll the date forward by one day
   always_comb begin
      roll_day   = cal_ff.day;
      roll_month = cal_ff.month;
      roll_year  = cal_ff.year;
      if (cal_ff.day < rtc_pkg::month_length(cal_ff.month, cal_ff.year)) begin
         roll_day = cal_ff.day + 5'd1;
      end else begin
         roll_day = 5'd1;
         if (cal_ff.month >= 4'(rtc_pkg::MONTH_MAX)) begin
            roll_month = 4'd1;
            roll_year  = (cal_ff.year >= 7'(rtc_pkg::YEAR_MAX)) ? 7'd0 : cal_ff.year + 7'd1;
         end else begin
            roll_month = cal_ff.month + 4'd1;
         end
      end
   end

   // Weekday of the new date, from the set values or the rolled date
   always_comb begin
      if (req.op == rtc_pkg::OP_SET_DATE) begin
         wd_day   = set_d[4:0];
         wd_month = set_mo[3:0];
         wd_year  = set_y[6:0];
      end else begin
         wd_day   = roll_day;
         wd_month = roll_month;
         wd_year  = roll_year;
      end
      wd_new = rtc_pkg::calc_weekday(wd_day, wd_month, wd_year);
   end

   // Work out the updated calendar for this transaction
   always_comb begin
      cal_in = cal_ff;
      status = 1'b0;
      unique case (req.op)
         rtc_pkg::OP_TICK: begin
            if (cal_ff.second < 6'(rtc_pkg::MINSEC_MAX)) begin
               cal_in.second = cal_ff.second + 6'd1;
            end else begin
               cal_in.second = 6'd0;
               if (cal_ff.minute < 6'(rtc_pkg::MINSEC_MAX)) begin
                  cal_in.minute = cal_ff.minute + 6'd1;
               end else begin
                  cal_in.minute = 6'd0;
                  if (cal_ff.hour < 5'(rtc_pkg::HOUR_MAX)) begin
                     cal_in.hour = cal_ff.hour + 5'd1;
                  end else begin
                     cal_in.hour    = 5'd0;
                     cal_in.day     = roll_day;
                     cal_in.month   = roll_month;
                     cal_in.year    = roll_year;
                     cal_in.weekday = wd_new;
                  end
               end
            end
         end
         rtc_pkg::OP_SET_TIME: begin
            if (time_bad) begin
               status = 1'b1;
            end else begin
               cal_in.hour   = set_h[4:0];
               cal_in.minute = set_mi[5:0];
               cal_in.second = set_s[5:0];
            end
         end
         rtc_pkg::OP_SET_DATE: begin
            if (date_bad) begin
               status = 1'b1;
            end else begin
               cal_in.day     = set_d[4:0];
               cal_in.month   = set_mo[3:0];
               cal_in.year    = set_y[6:0];
               cal_in.weekday = wd_new;
            end
         end
         rtc_pkg::OP_READ: begin
            cal_in = cal_ff;
         end
         default: begin
            cal_in = cal_ff;
         end
      endcase
   end

   // Commit the update when the transaction is processed
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff.hour    <= 5'd0;
         cal_ff.minute  <= 6'd0;
         cal_ff.second  <= 6'd0;
         cal_ff.day     <= 5'd1;
         cal_ff.month   <= 4'd1;
         cal_ff.year    <= 7'd0;
         cal_ff.weekday <= 3'd0;
      end else if (fire) begin
         cal_ff <= cal_in;
      end
   end

   assign cal_cur = cal_ff;
   assign cal_upd = cal_in;

endmodule

// ----- bench/rtc_time_and_calendar_tb.sv -----
// ----------------------------------------------------------------------------
// Real-time clock and calendar testbench
// Sends ticks, time and date settings and reads through the request channel,
// computes the expected clock contents with a local calendar predictor and
// compares every response field by field, with random gaps on both channels.
// ----------------------------------------------------------------------------
module rtc_time_and_calendar_tb;

   // One response as the block should present it
   typedef struct packed {
      logic       status;
      logic [5:0] hour;
      logic [6:0] minute;
      logic [6:0] second;
      logic [5:0] day;
      logic [4:0] month;
      logic [7:0] year;
      logic [2:0] weekday;
   } reading_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_op;
   logic       req_bcd;
   logic [7:0] req_set_hour;
   logic [7:0] req_set_minute;
   logic [7:0] req_set_second;
   logic [7:0] req_set_day;
   logic [7:0] req_set_month;
   logic [7:0] req_set_year;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_status;
   logic [5:0] rsp_out_hour;
   logic [6:0] rsp_out_minute;
   logic [6:0] rsp_out_second;
   logic [5:0] rsp_out_day;
   logic [4:0] rsp_out_month;
   logic [7:0] rsp_out_year;
   logic [2:0] rsp_out_weekday;

   // Predicted clock contents
   logic [4:0] cal_hour;
   logic [5:0] cal_minute;
   logic [5:0] cal_second;
   logic [4:0] cal_day;
   logic [3:0] cal_month;
   logic [6:0] cal_year;
   logic [2:0] cal_weekday;

   reading_type pending_readings[$];
   reading_type want_reading;
   int          mismatch_count;
   bit          sender_idle;
   bit          receiver_idle;

   rtc_time_and_calendar uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_bcd         (req_bcd),
      .req_set_hour    (req_set_hour),
      .req_set_minute  (req_set_minute),
      .req_set_second  (req_set_second),
      .req_set_day     (req_set_day),
      .req_set_month   (req_set_month),
      .req_set_year    (req_set_year),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_out_hour    (rsp_out_hour),
      .rsp_out_minute  (rsp_out_minute),
      .rsp_out_second  (rsp_out_second),
      .rsp_out_day     (rsp_out_day),
      .rsp_out_month   (rsp_out_month),
      .rsp_out_year    (rsp_out_year),
      .rsp_out_weekday (rsp_out_weekday)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Calendar predictor
   // ------------------------------------------------------------------------

   function automatic int bcd_to_bin(input logic [7:0] v);
      return int'(v[7:4]) * 10 + int'(v[3:0]);
   endfunction

   function automatic logic [7:0] bin_to_bcd(input int v);
      return {4'(v / 10), 4'(v % 10)};
   endfunction

   function automatic logic [7:0] encode_value(input int v, input logic bcd);
      return bcd ? bin_to_bcd(v) : 8'(v);
   endfunction

   // Day of week, 0 is Sunday, for a date in 2000..2099
   function automatic logic [2:0] weekday_of(input int d, input int m, input int y);
      int yr;
      int sum;
      yr = 2000 + y;
      if (m < 3) begin
         sum = (23 * m) / 9 + d + 4 + yr + (yr - 1) / 4 - (yr - 1) / 100 + (yr - 1) / 400;
      end else begin
         sum = (23 * m) / 9 + d + 4 + yr + yr / 4 - yr / 100 + yr / 400 - 2;
      end
      return 3'(sum % 7);
   endfunction

   // Apply one transaction to the predicted state and format the response
   function automatic reading_type predict_reading(input logic [1:0] op, input logic bcd,
                                                   input logic [7:0] h_in, mi_in, s_in,
                                                   input logic [7:0] d_in, mo_in, y_in);
      reading_type r;
      int          h;
      int          mi;
      int          s;
      int          mlen;
      r = '0;
      unique case (op)
         rtc_pkg::OP_TICK: begin
            if (cal_second < 59) begin
               cal_second = cal_second + 6'd1;
            end else begin
               cal_second = 6'd0;
               if (cal_minute < 59) begin
                  cal_minute = cal_minute + 6'd1;
               end else begin
                  cal_minute = 6'd0;
                  if (cal_hour < 23) begin
                     cal_hour = cal_hour + 5'd1;
                  end else begin
                     // Midnight: advance the date
                     cal_hour = 5'd0;
                     if (cal_month == 2) begin
                        mlen = (cal_year[1:0] == 2'b00) ? 29 : 28;
                     end else if (cal_month == 4 || cal_month == 6 || cal_month == 9 ||
                                  cal_month == 11) begin
                        mlen = 30;
                     end else begin
                        mlen = 31;
                     end
                     if (cal_day < mlen) begin
                        cal_day = cal_day + 5'd1;
                     end else begin
                        cal_day = 5'd1;
                        if (cal_month >= 12) begin
                           cal_month = 4'd1;
                           cal_year  = (cal_year >= 99) ? 7'd0 : cal_year + 7'd1;
                        end else begin
                           cal_month = cal_month + 4'd1;
                        end
                     end
                     cal_weekday = weekday_of(int'(cal_day), int'(cal_month), int'(cal_year));
                  end
               end
            end
         end
         rtc_pkg::OP_SET_TIME: begin
            h  = bcd ? bcd_to_bin(h_in)  : int'(h_in);
            mi = bcd ? bcd_to_bin(mi_in) : int'(mi_in);
            s  = bcd ? bcd_to_bin(s_in)  : int'(s_in);
            if (h > 23 || mi > 59 || s > 59) begin
               r.status = 1'b1;
            end else begin
               cal_hour   = 5'(h);
               cal_minute = 6'(mi);
               cal_second = 6'(s);
            end
         end
         rtc_pkg::OP_SET_DATE: begin
            h  = bcd ? bcd_to_bin(d_in)  : int'(d_in);
            mi = bcd ? bcd_to_bin(mo_in) : int'(mo_in);
            s  = bcd ? bcd_to_bin(y_in)  : int'(y_in);
            if (h < 1 || h > 31 || mi < 1 || mi > 12 || s > 99) begin
               r.status = 1'b1;
            end else begin
               cal_day     = 5'(h);
               cal_month   = 4'(mi);
               cal_year    = 7'(s);
               cal_weekday = weekday_of(h, mi, s);
            end
         end
         default: begin
         end
      endcase
      r.hour    = 6'(encode_value(int'(cal_hour), bcd));
      r.minute  = 7'(encode_value(int'(cal_minute), bcd));
      r.second  = 7'(encode_value(int'(cal_second), bcd));
      r.day     = 6'(encode_value(int'(cal_day), bcd));
      r.month   = 5'(encode_value(int'(cal_month), bcd));
      r.year    = encode_value(int'(cal_year), bcd);
      r.weekday = cal_weekday;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------------

   // Send one transaction and queue its predicted response on acceptance
   task automatic send_item(input logic [1:0] op, input logic bcd,
                            input logic [7:0] h, mi, s, d, mo, y);
      int gap;
      gap = sender_idle ? $urandom_range(0, 13) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_bcd        <= bcd;
      req_set_hour   <= h;
      req_set_minute <= mi;
      req_set_second <= s;
      req_set_day    <= d;
      req_set_month  <= mo;
      req_set_year   <= y;
      do @(posedge clock); while (!req_ready);
      pending_readings.push_back(predict_reading(op, bcd, h, mi, s, d, mo, y));
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------------
   // Response side: random stalls and field checks
   // ------------------------------------------------------------------------

   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = receiver_idle ? $urandom_range(0, 13) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_readings.size() == 0) begin
            report_mismatch("response with nothing pending", 1, 0);
         end else begin
            want_reading = pending_readings.pop_front();
            if (rsp_status !== want_reading.status)
               report_mismatch("status", int'(rsp_status), int'(want_reading.status));
            if (rsp_out_hour !== want_reading.hour)
               report_mismatch("hour", int'(rsp_out_hour), int'(want_reading.hour));
            if (rsp_out_minute !== want_reading.minute)
               report_mismatch("minute", int'(rsp_out_minute), int'(want_reading.minute));
            if (rsp_out_second !== want_reading.second)
               report_mismatch("second", int'(rsp_out_second), int'(want_reading.second));
            if (rsp_out_day !== want_reading.day)
               report_mismatch("day", int'(rsp_out_day), int'(want_reading.day));
            if (rsp_out_month !== want_reading.month)
               report_mismatch("month", int'(rsp_out_month), int'(want_reading.month));
            if (rsp_out_year !== want_reading.year)
               report_mismatch("year", int'(rsp_out_year), int'(want_reading.year));
            if (rsp_out_weekday !== want_reading.weekday)
               report_mismatch("weekday", int'(rsp_out_weekday),
                               int'(want_reading.weekday));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Read the reset contents in both formats
   task automatic test_reset_state();
      send_item(rtc_pkg::OP_READ, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_item(rtc_pkg::OP_READ, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
   endtask

   // Accept limits, reject one past each limit, accept BCD nibbles above nine
   task automatic test_time_setting();
      send_item(rtc_pkg::OP_SET_TIME, 1'b0, 8'd23, 8'd59, 8'd59, 8'd0, 8'd0, 8'd0);
      send_item(rtc_pkg::OP_SET_TIME, 1'b0, 8'd24, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1);
      send_item(rtc_pkg::OP_SET_TIME, 1'b0, 8'd0, 8'd60, 8'd0, 8'd1, 8'd1, 8'd1);
      send_item(rtc_pkg::OP_SET_TIME, 1'b1, 8'h00, 8'h00, 8'h60, 8'h01, 8'h01, 8'h01);
      send_item(rtc_pkg::OP_SET_TIME, 1'b1, 8'h0F, 8'h4F, 8'h0A, 8'h00, 8'h00, 8'h00);
      send_item(rtc_pkg::OP_SET_TIME, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
   endtask

   // Reject each out-of-range date field, accept the BCD maxima
   task automatic test_date_setting();
      send_item(rtc_pkg::OP_SET_DATE, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd6, 8'd10);
      send_item(rtc_pkg::OP_SET_DATE, 1'b0, 8'd0, 8'd0, 8'd0, 8'd32, 8'd6, 8'd10);
      send_item(rtc_pkg::OP_SET_DATE, 1'b1, 8'd0, 8'd0, 8'd0, 8'h15, 8'h13, 8'h10);
      send_item(rtc_pkg::OP_SET_DATE, 1'b0, 8'd0, 8'd0, 8'd0, 8'd15, 8'd0, 8'd100);
      send_item(rtc_pkg::OP_SET_DATE, 1'b1, 8'hAA, 8'h55, 8'hFF, 8'h31, 8'h12, 8'h99);
   endtask

   // Cross midnight at year end, a short month overrun and February both ways
   task automatic test_midnight_rollover();
      send_item(rtc_pkg::OP_SET_TIME, 1'b0, 8'd23, 8'd59, 8'd59, 8'd0, 8'd0, 8'd0);
      send_item(rtc_pkg::OP_TICK, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_item(rtc_pkg::OP_SET_DATE, 1'b1, 8'h00, 8'h00, 8'h00, 8'h31, 8'h04, 8'h21);
      send_item(rtc_pkg::OP_SET_TIME, 1'b1, 8'h23, 8'h59, 8'h59, 8'h00, 8'h00, 8'h00);
      send_item(rtc_pkg::OP_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(rtc_pkg::OP_SET_DATE, 1'b0, 8'd0, 8'd0, 8'd0, 8'd28, 8'd2, 8'd4);
      send_item(rtc_pkg::OP_SET_TIME, 1'b0, 8'd23, 8'd59, 8'd59, 8'd0, 8'd0, 8'd0);
      send_item(rtc_pkg::OP_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(rtc_pkg::OP_SET_DATE, 1'b0, 8'd0, 8'd0, 8'd0, 8'd28, 8'd2, 8'd1);
      send_item(rtc_pkg::OP_SET_TIME, 1'b0, 8'd23, 8'd59, 8'd59, 8'd0, 8'd0, 8'd0);
      send_item(rtc_pkg::OP_TICK, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
   endtask

   // Ticks and settings aimed at midnight and month ends, with noise and reads
   task automatic test_random_traffic(input int count);
      int         kind;
      logic       b;
      logic [7:0] f[6];
      int         h;
      int         mi;
      int         s;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            sender_idle   = ($urandom_range(0, 2) != 0);
            receiver_idle = ($urandom_range(0, 2) != 0);
         end
         kind = $urandom_range(0, 99);
         b    = 1'($urandom_range(0, 1));
         foreach (f[k]) f[k] = 8'($urandom_range(0, 255));
         if (kind < 45) begin
            send_item(rtc_pkg::OP_TICK, b, f[0], f[1], f[2], f[3], f[4], f[5]);
         end else if (kind < 62) begin
            // Valid time, usually just before midnight
            if (kind < 55) begin
               h  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 23) : 23;
               mi = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 59) : 59;
               s  = $urandom_range(50, 59);
            end else begin
               h  = $urandom_range(0, 23);
               mi = $urandom_range(0, 59);
               s  = $urandom_range(0, 59);
            end
            send_item(rtc_pkg::OP_SET_TIME, b, encode_value(h, b), encode_value(mi, b),
                      encode_value(s, b), f[3], f[4], f[5]);
         end else if (kind < 72) begin
            // Valid date, usually near the end of a month
            h  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 31) : $urandom_range(27, 31);
            mi = $urandom_range(1, 12);
            s  = ($urandom_range(0, 3) == 0) ? 99 : $urandom_range(0, 99);
            send_item(rtc_pkg::OP_SET_DATE, b, f[0], f[1], f[2], encode_value(h, b),
                      encode_value(mi, b), encode_value(s, b));
         end else if (kind < 80) begin
            // Raw bytes, mostly rejected
            send_item(kind < 76 ? rtc_pkg::OP_SET_TIME : rtc_pkg::OP_SET_DATE, b,
                      f[0], f[1], f[2], f[3], f[4], f[5]);
         end else begin
            send_item(rtc_pkg::OP_READ, b, f[0], f[1], f[2], f[3], f[4], f[5]);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      int guard;
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_op         = rtc_pkg::OP_TICK;
      req_bcd        = 1'b0;
      req_set_hour   = 8'd0;
      req_set_minute = 8'd0;
      req_set_second = 8'd0;
      req_set_day    = 8'd0;
      req_set_month  = 8'd0;
      req_set_year   = 8'd0;
      mismatch_count = 0;
      sender_idle    = 1'b1;
      receiver_idle  = 1'b1;
      cal_hour       = 5'd0;
      cal_minute     = 6'd0;
      cal_second     = 6'd0;
      cal_day        = 5'd1;
      cal_month      = 4'd1;
      cal_year       = 7'd0;
      cal_weekday    = 3'd0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_time_setting();
      test_date_setting();
      test_midnight_rollover();
      test_random_traffic(800);

      // Drain outstanding responses
      @(negedge clock);
      req_valid <= 1'b0;
      guard = 0;
      while (pending_readings.size() != 0 && guard < 2000) begin
         @(posedge clock);
         guard++;
      end
      repeat (5) @(posedge clock);
      if (pending_readings.size() != 0)
         report_mismatch("transactions left unanswered", pending_readings.size(), 0);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #3000000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ----- rtc_time_and_calendar.f -----
+incdir+rtl/core
rtl/core/rtc_pkg.sv
rtl/core/rtc_core.sv
rtl/core/rtc_time_and_calendar.sv
bench/rtc_time_and_calendar_tb.sv
